// File: rtl/avsc_pkg.sv
// Shared types and constants for the audio/video sync counter pair.
package avsc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 33;
  localparam int unsigned DivW  = 16;

  // control register bit positions
  localparam int unsigned CtrlEnLsb    = 0;
  localparam int unsigned CtrlPauseLsb = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } avsc_op_e;

  typedef enum logic [1:0] {
    REG_CTRL = 2'd0,
    REG_CNT0 = 2'd1,
    REG_CNT1 = 2'd2,
    REG_DIV  = 2'd3
  } avsc_reg_e;

  typedef struct packed {
    avsc_op_e         op;
    avsc_reg_e        reg_index;
    logic [DataW-1:0] write_data;
  } avsc_req_t;

  typedef struct packed {
    logic tick;   // advance prescaler this cycle
    logic load;   // bus write of bits 32:1
  } avsc_cnt_cmd_t;

endpackage

// File: rtl/av_sync_counter_pair.sv
// Top level: two audio/video sync counters behind four bus registers.
// Pipeline: a request is registered on acceptance and its result is registered
//   when the held request executes, which waits while the result register is full.
// Throughput: one request per cycle (ticks, writes and reads alike) while the
//   result side keeps taking results.
// Reset: rst_ni clears control, divisors, counters and prescalers to zero.
module av_sync_counter_pair
  import avsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [1:0]       reg_index_i,
  input  logic [DataW-1:0] write_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] read_data_o
);

  // ---------------------------------------------------------------------
  // Request stage
  // ---------------------------------------------------------------------
  logic      req_valid;
  avsc_req_t req;
  logic      adv;          // held request is executed this cycle

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] rdata_q, rdata_d;

  // Execute whenever the result register is free or being drained.
  assign adv = req_valid && (!out_valid_q || out_ready_i);

  avsc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .take_i       (adv),
    .valid_o      (req_valid),
    .req_o        (req)
  );

  // ---------------------------------------------------------------------
  // Control and divisor registers
  // ---------------------------------------------------------------------
  logic [1:0]            en_q, en_d;
  logic [1:0]            pause_q, pause_d;
  logic [1:0][DivW-1:0]  div_q, div_d;

  logic is_tick, is_write, is_read;
  assign is_tick  = adv && (req.op == OP_TICK);
  assign is_write = adv && (req.op == OP_WRITE);
  assign is_read  = adv && (req.op == OP_READ);

  always_comb begin
    en_d    = en_q;
    pause_d = pause_q;
    div_d   = div_q;
    if (is_write) begin
      unique case (req.reg_index)
        REG_CTRL: begin
          // unused control bits are dropped
          en_d    = req.write_data[CtrlEnLsb +: 2];
          pause_d = req.write_data[CtrlPauseLsb +: 2];
        end
        REG_DIV: begin
          // prescalers keep their values on a divisor write
          div_d[0] = req.write_data[DivW-1:0];
          div_d[1] = req.write_data[2*DivW-1:DivW];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= '0;
      pause_q <= '0;
      div_q   <= '0;
    end else begin
      en_q    <= en_d;
      pause_q <= pause_d;
      div_q   <= div_d;
    end
  end

  // ---------------------------------------------------------------------
  // Counters: a tick advances each enabled, unpaused counter
  // ---------------------------------------------------------------------
  avsc_cnt_cmd_t   cmd0, cmd1;
  logic [CntW-1:0] cnt0, cnt1;

  assign cmd0.tick = is_tick && en_q[0] && !pause_q[0];
  assign cmd1.tick = is_tick && en_q[1] && !pause_q[1];
  assign cmd0.load = is_write && (req.reg_index == REG_CNT0);
  assign cmd1.load = is_write && (req.reg_index == REG_CNT1);

  avsc_counter u_cnt0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd0),
    .load_val_i (req.write_data),
    .divisor_i  (div_q[0]),
    .count_o    (cnt0)
  );

  avsc_counter u_cnt1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd1),
    .load_val_i (req.write_data),
    .divisor_i  (div_q[1]),
    .count_o    (cnt1)
  );

  // ---------------------------------------------------------------------
  // Read mux and result register; ticks, writes and unused ops return zero
  // ---------------------------------------------------------------------
  always_comb begin
    rdata_d = '0;
    if (is_read) begin
      unique case (req.reg_index)
        REG_CTRL: begin
          rdata_d[CtrlEnLsb +: 2]    = en_q;
          rdata_d[CtrlPauseLsb +: 2] = pause_q;
        end
        REG_CNT0: rdata_d = cnt0[CntW-1:1];
        REG_CNT1: rdata_d = cnt1[CntW-1:1];
        REG_DIV:  rdata_d = {div_q[1], div_q[0]};
        default:  rdata_d = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= rdata_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid |-> in_ready_o)
    else $error("request stage empty but not ready");

  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (req.op != OP_READ) |=> (read_data_o == '0))
    else $error("tick or write returned nonzero data");

  a_load_lsb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd0.load |=> (cnt0[0] == 1'b0))
    else $error("counter write left bit 0 set");

  a_idle_hold0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd0.tick && !cmd0.load |=> $stable(cnt0))
    else $error("counter zero moved without tick or write");

  a_idle_hold1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd1.tick && !cmd1.load |=> $stable(cnt1))
    else $error("counter one moved without tick or write");

endmodule

// File: rtl/avsc_in_reg.sv
// Input request register with valid/ready handshake.
module avsc_in_reg
  import avsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [1:0]       reg_index_i,
  input  logic [DataW-1:0] write_data_i,
  input  logic             take_i,     // downstream consumes the held request
  output logic             valid_o,
  output avsc_req_t        req_o
);

  logic      valid_q, valid_d;
  avsc_req_t req_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.op         <= avsc_op_e'(op_i);
      req_q.reg_index  <= avsc_reg_e'(reg_index_i);
      req_q.write_data <= write_data_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// File: rtl/avsc_counter.sv
// One 33-bit sync counter with its 16-bit prescaler.
module avsc_counter
  import avsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  avsc_cnt_cmd_t    cmd_i,
  input  logic [DataW-1:0] load_val_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic [CntW-1:0]  count_o
);

  logic [CntW-1:0] count_q, count_d;
  logic [DivW-1:0] pre_q, pre_d;

  always_comb begin
    count_d = count_q;
    pre_d   = pre_q;
    if (cmd_i.load) begin
      count_d = {load_val_i, 1'b0};
      pre_d   = '0;
    end else if (cmd_i.tick) begin
      // at or past the divisor: restart and count (also after divisor lowered)
      if (pre_q >= divisor_i) begin
        pre_d   = '0;
        count_d = count_q + CntW'(1);
      end else begin
        pre_d = pre_q + DivW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pre_q   <= '0;
    end else begin
      count_q <= count_d;
      pre_q   <= pre_d;
    end
  end

  assign count_o = count_q;

endmodule

// File: bench/avsc_checker.sv
// Scoreboard for the sync counter pair: tracks register and counter state and checks read_data.
module avsc_checker
  import avsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [1:0]       op_i,
  input  logic [1:0]       reg_index_i,
  input  logic [DataW-1:0] write_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [DataW-1:0] read_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the block's state
  logic [1:0]       enable_q;
  logic [1:0]       pause_q;
  logic [CntW-1:0]  count_q [2];
  logic [DivW-1:0]  divisor_q [2];
  logic [DivW-1:0]  prescale_q [2];

  logic [DataW-1:0] read_data_queue [$];
  int unsigned      fail_count = 0;
  int unsigned      pending    = 0;
  int unsigned      results    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign results_o    = results;

  task automatic advance_counter(input int k);
    if (enable_q[k] && !pause_q[k]) begin
      if (prescale_q[k] >= divisor_q[k]) begin
        prescale_q[k] = '0;
        count_q[k]    = count_q[k] + 1'b1;  // wraps at 2^33
      end else begin
        prescale_q[k] = prescale_q[k] + 1'b1;
      end
    end
  endtask

  // Applies one request to the shadow state and returns the read_data it should produce.
  task automatic predict_read_data(input logic [1:0] op, input logic [1:0] idx,
                                   input logic [DataW-1:0] wdata,
                                   output logic [DataW-1:0] rdata);
    int k;
    k     = (idx == REG_CNT0) ? 0 : 1;
    rdata = '0;
    case (op)
      OP_TICK: begin
        advance_counter(0);
        advance_counter(1);
      end
      OP_WRITE: begin
        case (idx) inside
          REG_CTRL: begin
            enable_q = wdata[CtrlEnLsb +: 2];
            pause_q  = wdata[CtrlPauseLsb +: 2];
          end
          REG_CNT0, REG_CNT1: begin
            count_q[k]    = {wdata, 1'b0};
            prescale_q[k] = '0;
          end
          default: begin
            divisor_q[0] = wdata[DivW-1:0];
            divisor_q[1] = wdata[2*DivW-1:DivW];
          end
        endcase
      end
      OP_READ: begin
        case (idx) inside
          REG_CTRL: begin
            rdata[CtrlEnLsb +: 2]    = enable_q;
            rdata[CtrlPauseLsb +: 2] = pause_q;
          end
          REG_CNT0, REG_CNT1: rdata = count_q[k][CntW-1:1];
          default:            rdata = {divisor_q[1], divisor_q[0]};
        endcase
      end
      default: ;  // unused op: no effect, zero result
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [DataW-1:0] expected;
    if (!rst_ni) begin
      enable_q      = '0;
      pause_q       = '0;
      count_q[0]    = '0;
      count_q[1]    = '0;
      divisor_q[0]  = '0;
      divisor_q[1]  = '0;
      prescale_q[0] = '0;
      prescale_q[1] = '0;
      read_data_queue.delete();
      pending = 0;
    end else begin
      // results first: a result at this edge always belongs to an older request
      if (out_valid_i && out_ready_i) begin
        results++;
        if (read_data_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, nothing pending: expected none, actual %h",
                   $time, read_data_i);
        end else begin
          expected = read_data_queue.pop_front();
          pending--;
          if (read_data_i !== expected) begin
            fail_count++;
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, expected, read_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_read_data(op_i, reg_index_i, write_data_i, expected);
        read_data_queue.push_back(expected);
        pending++;
      end
    end
  end

endmodule

// File: bench/av_sync_counter_pair_tb.sv
// Top of the sync counter pair bench: clock, reset, request traffic, result sink and verdict.
module av_sync_counter_pair_tb
  import avsc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 925;
  localparam int unsigned HoldCycles  = 250;   // long receiver hold-off
  localparam int unsigned HoldAfter   = 300;   // results seen before the hold-off starts
  localparam int unsigned StallLimit  = 2000;  // cycles with no handshake on either side
  localparam int unsigned DrainCycles = 8;     // settle time after the last result
  localparam logic [1:0]  OpUnused    = 2'd3;  // op code with no function

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid     = 1'b0;
  logic [1:0]       op           = OP_TICK;
  logic [1:0]       reg_index    = REG_CTRL;
  logic [DataW-1:0] write_data   = '0;
  logic             out_ready    = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [DataW-1:0] read_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;

  // request mix, for the summary
  int unsigned tick_reqs   = 0;
  int unsigned write_reqs  = 0;
  int unsigned read_reqs   = 0;
  int unsigned unused_reqs = 0;

  av_sync_counter_pair dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .reg_index_i  (reg_index),
    .write_data_i (write_data),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data)
  );

  avsc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op),
    .reg_index_i  (reg_index),
    .write_data_i (write_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_i  (read_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // Presents one request at the current edge and returns at the edge where it is
  // taken. Valid stays up, so back-to-back calls give a gapless burst.
  task automatic issue_request(input logic [1:0] req_op, input logic [1:0] req_idx,
                               input logic [DataW-1:0] req_data);
    in_valid   <= 1'b1;
    op         <= req_op;
    reg_index  <= req_idx;
    write_data <= req_data;
    case (req_op)
      OP_TICK:  tick_reqs++;
      OP_WRITE: write_reqs++;
      OP_READ:  read_reqs++;
      default:  unused_reqs++;
    endcase
    do @(posedge clk_i); while (!in_ready);
  endtask

  // One random request. Mostly ticks and reads so the counters move and get
  // observed; writes lean toward settings that keep counters running fast.
  task automatic random_request();
    int unsigned pick;
    logic [DataW-1:0] raw;
    logic [1:0] idx;
    logic [1:0] en;
    logic [1:0] pause;
    pick = $urandom_range(0, 99);
    raw  = $urandom;
    idx  = 2'($urandom_range(0, 3));
    if (pick < 50) begin
      issue_request(OP_TICK, idx, raw);
    end else if (pick < 78) begin
      issue_request(OP_READ, idx, raw);
    end else if (pick < 95) begin
      case (idx) inside
        REG_CTRL: begin
          // usually both counters running and unpaused; junk in the unused bits
          en    = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b11;
          pause = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b00;
          raw[CtrlEnLsb +: 2]    = en;
          raw[CtrlPauseLsb +: 2] = pause;
        end
        REG_CNT0, REG_CNT1: begin
          // near the top of the range so the 33-bit wrap gets exercised
          if ($urandom_range(0, 3) == 0)
            raw = 32'hFFFF_FFFF - $urandom_range(0, 15);
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       ;  // fully random divisors
            1:       raw = {16'($urandom_range(0, 3)), 16'hFFFF};
            default: raw = {16'($urandom_range(0, 5)), 16'($urandom_range(0, 5))};
          endcase
        end
      endcase
      issue_request(OP_WRITE, idx, raw);
    end else begin
      issue_request(OpUnused, idx, raw);
    end
  endtask

  // Request side: reset, a directed opening, then random bursts with gaps.
  initial begin : request_source
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of every register
    issue_request(OP_READ,  REG_CTRL, 32'hFFFF_FFFF);
    issue_request(OP_READ,  REG_CNT0, 32'h0);
    issue_request(OP_READ,  REG_CNT1, 32'h0);
    issue_request(OP_READ,  REG_DIV,  32'h0);
    // control write with only unused bits set: reads back zero
    issue_request(OP_WRITE, REG_CTRL, 32'hFFFF_FCFC);
    issue_request(OP_READ,  REG_CTRL, 32'h0);
    // both counters enabled, divisor zero: increment on every tick
    issue_request(OP_WRITE, REG_CTRL, 32'h0000_0003);
    issue_request(OP_WRITE, REG_CNT0, 32'hFFFF_FFFF);
    issue_request(OP_WRITE, REG_CNT1, 32'h0000_0000);
    issue_request(OP_TICK,  REG_CTRL, 32'hFFFF_FFFF);
    issue_request(OP_READ,  REG_CNT0, 32'h0);
    issue_request(OP_TICK,  REG_DIV,  32'h0);         // counter zero wraps past 2^33
    issue_request(OP_READ,  REG_CNT0, 32'h0);
    // divisor zero at maximum, divisor one at three
    issue_request(OP_WRITE, REG_DIV,  32'h0003_FFFF);
    issue_request(OP_READ,  REG_DIV,  32'h0);
    issue_request(OP_TICK,  REG_CNT0, 32'h0);
    issue_request(OP_TICK,  REG_CNT1, 32'h0);
    // lower the divisors under the prescalers: next tick must roll both counters
    issue_request(OP_WRITE, REG_DIV,  32'h0000_0000);
    issue_request(OP_TICK,  REG_CTRL, 32'h0);
    issue_request(OP_READ,  REG_CNT1, 32'h0);
    // pause counter zero, keep counter one running
    issue_request(OP_WRITE, REG_CTRL, 32'h0000_0103);
    issue_request(OP_TICK,  REG_CTRL, 32'h0);
    issue_request(OP_READ,  REG_CNT0, 32'h0);
    // unused op with every data bit set
    issue_request(OpUnused, REG_DIV,  32'hFFFF_FFFF);
    issue_request(OP_READ,  REG_CTRL, 32'h0);

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RandomItems; i++) begin
        random_request();
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;

    // drain: every expected result must come back; the watchdog covers a hang
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("av_sync_counter_pair_tb: %0d requests: %0d ticks, %0d writes, %0d reads,",
             tick_reqs + write_reqs + read_reqs + unused_reqs,
             tick_reqs, write_reqs, read_reqs);
    $display("av_sync_counter_pair_tb: %0d unused op, %0d results checked, one long hold-off",
             unused_reqs, results);
    if (fail_count == 0)
      $display("av_sync_counter_pair_tb: PASS");
    else
      $display("av_sync_counter_pair_tb: FAIL");
    $finish;
  end

  // Result side: stretches of always-ready, coin-flip and mostly-stalled, plus
  // one long hold-off so the block backs up and drops in_ready.
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    bit held;
    mode = 0;
    span = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results >= HoldAfter) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(1, 40);
        end
        span--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("av_sync_counter_pair_tb: FAIL");
    $finish;
  end

endmodule
